@@ rtl/core/yuv422_nearest_downscaler_defines.svh @@
// ----------------------------------------------------------------------------
// YUV422 nearest downscaler assertion macros
// Shared assertion wrappers for the downscaler RTL.
// ----------------------------------------------------------------------------
`ifndef YUV422_NEAREST_DOWNSCALER_DEFINES_SVH
`define YUV422_NEAREST_DOWNSCALER_DEFINES_SVH

// Concurrent assertion of a whole property, sampled on the rising clock.
`define YDS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent assertion that a trigger implies a condition in the same cycle.
`define YDS_IMPLY(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

`endif

@@ rtl/core/yuvds_pkg.sv @@
// ----------------------------------------------------------------------------
// YUV422 downscaler package
// Field widths, configuration register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package yuvds_pkg;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	localparam int PIX_W     = 8;
	localparam int SIZE_W    = 12;
	localparam int COORD_W   = 11;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_TARGET_WIDTH  = 2'd2,
		REG_TARGET_HEIGHT = 2'd3
	} cfg_reg_t;

	localparam logic [SIZE_W-1:0] RST_SOURCE_WIDTH  = 12'd240;
	localparam logic [SIZE_W-1:0] RST_SOURCE_HEIGHT = 12'd520;
	localparam logic [SIZE_W-1:0] RST_TARGET_WIDTH  = 12'd240;
	localparam logic [SIZE_W-1:0] RST_TARGET_HEIGHT = 12'd520;

	typedef struct packed {
		logic [SIZE_W-1:0] sw;
		logic [SIZE_W-1:0] sh;
		logic [SIZE_W-1:0] dw;
		logic [SIZE_W-1:0] dh;
		logic              restart;
	} sizes_t;

	typedef struct packed {
		logic [PIX_W-1:0]   u;
		logic [PIX_W-1:0]   y0;
		logic [PIX_W-1:0]   v;
		logic [PIX_W-1:0]   y1;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               frame_end;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/core/yuvds_cfg.sv @@
// ----------------------------------------------------------------------------
// YUV422 downscaler configuration
// Size registers, write decode and clamping to the effective frame sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module yuvds_cfg #(
	parameter int MAX_WIDTH  = yuvds_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = yuvds_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	input  wire logic [yuvds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [yuvds_pkg::SIZE_W-1:0]       cfg_data,
	output yuvds_pkg::sizes_t                       sizes
);
	import yuvds_pkg::*;

	localparam int MAX_W_EVEN = MAX_WIDTH - (MAX_WIDTH % 2);

	logic [SIZE_W-1:0] src_w_q;
	logic [SIZE_W-1:0] src_h_q;
	logic [SIZE_W-1:0] dst_w_q;
	logic [SIZE_W-1:0] dst_h_q;
	logic [SIZE_W-1:0] w;
	logic [SIZE_W-1:0] h;
	logic [SIZE_W-1:0] tw;
	logic [SIZE_W-1:0] th;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= RST_SOURCE_WIDTH;
			src_h_q <= RST_SOURCE_HEIGHT;
			dst_w_q <= RST_TARGET_WIDTH;
			dst_h_q <= RST_TARGET_HEIGHT;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SOURCE_WIDTH:  src_w_q <= cfg_data;
				REG_SOURCE_HEIGHT: src_h_q <= cfg_data;
				REG_TARGET_WIDTH:  dst_w_q <= cfg_data;
				REG_TARGET_HEIGHT: dst_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		w  = {src_w_q[SIZE_W-1:1], 1'b0};
		h  = src_h_q;
		tw = {dst_w_q[SIZE_W-1:1], 1'b0};
		th = dst_h_q;
		if (w < 12'd2)
			w = 12'd2;
		if (32'(w) > MAX_W_EVEN)
			w = SIZE_W'(MAX_W_EVEN);
		if (h < 12'd1)
			h = 12'd1;
		if (32'(h) > MAX_HEIGHT)
			h = SIZE_W'(MAX_HEIGHT);
		if (tw < 12'd2)
			tw = 12'd2;
		if (tw > w)
			tw = w;
		if (th < 12'd1)
			th = 12'd1;
		if (th > h)
			th = h;
	end

	assign sizes.sw      = w;
	assign sizes.sh      = h;
	assign sizes.dw      = tw;
	assign sizes.dh      = th;
	assign sizes.restart = cfg_valid;

endmodule

`default_nettype wire

@@ rtl/core/yuvds_select.sv @@
// ----------------------------------------------------------------------------
// YUV422 downscaler selection stage
// Input register, raster counters and running numerators; flags kept items.
// ----------------------------------------------------------------------------
`default_nettype none

module yuvds_select #(
	parameter int MAX_WIDTH  = yuvds_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = yuvds_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire yuvds_pkg::sizes_t               sizes,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [yuvds_pkg::PIX_W-1:0]     chroma_u,
	input  wire logic [yuvds_pkg::PIX_W-1:0]     luma_first,
	input  wire logic [yuvds_pkg::PIX_W-1:0]     chroma_v,
	input  wire logic [yuvds_pkg::PIX_W-1:0]     luma_second,
	input  wire logic                            res_free,
	output logic                                 res_valid,
	output yuvds_pkg::result_t                   res
);
	import yuvds_pkg::*;

	localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int PAIR_W  = (MAX_WIDTH >= 4) ? $clog2(MAX_WIDTH / 2) : 1;
	localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
	localparam int NUM_W   = 2 * $clog2(MAX_DIM + 1) + 2;

	logic              valid_s1;
	logic [PIX_W-1:0]  u_s1;
	logic [PIX_W-1:0]  y0_s1;
	logic [PIX_W-1:0]  v_s1;
	logic [PIX_W-1:0]  y1_s1;

	logic [PAIR_W-1:0] src_pair_q;
	logic [ROW_W-1:0]  src_row_q;
	logic [PAIR_W-1:0] dst_pair_q;
	logic [ROW_W-1:0]  dst_row_q;
	logic [NUM_W-1:0]  col_num_q;
	logic [NUM_W-1:0]  row_num_q;
	logic [NUM_W-1:0]  col_base_q;
	logic [NUM_W-1:0]  row_base_q;

	logic [NUM_W-1:0]  dw_pairs;
	logic [NUM_W-1:0]  sw_pairs;
	logic [NUM_W-1:0]  dh_x;
	logic [NUM_W-1:0]  sh_x;
	logic [NUM_W-1:0]  sw_x2;
	logic [NUM_W-1:0]  dw_x2;
	logic              row_hit;
	logic              col_hit;
	logic              hit;
	logic              go;
	logic              last_pair;
	logic              last_row;
	logic              src_row_end;
	logic              src_frame_end;

	assign dw_pairs = NUM_W'(sizes.dw[SIZE_W-1:1]);
	assign sw_pairs = NUM_W'(sizes.sw[SIZE_W-1:1]);
	assign dh_x     = NUM_W'(sizes.dh);
	assign sh_x     = NUM_W'(sizes.sh);
	assign sw_x2    = NUM_W'({sizes.sw, 1'b0});
	assign dw_x2    = NUM_W'({sizes.dw, 1'b0});

	assign row_hit = (NUM_W'(dst_row_q) < dh_x) && (row_num_q >= row_base_q) &&
		(row_num_q < row_base_q + dh_x);
	assign col_hit = (NUM_W'(dst_pair_q) < dw_pairs) && (col_num_q >= col_base_q) &&
		(col_num_q < col_base_q + dw_x2);
	assign hit     = valid_s1 && row_hit && col_hit;
	assign go      = valid_s1 && (!hit || res_free);
	assign in_stall = valid_s1 && !go;

	assign last_pair     = NUM_W'(dst_pair_q) + 1'b1 >= dw_pairs;
	assign last_row      = NUM_W'(dst_row_q) + 1'b1 >= dh_x;
	assign src_row_end   = NUM_W'(src_pair_q) + 1'b1 >= sw_pairs;
	assign src_frame_end = src_row_end && (NUM_W'(src_row_q) + 1'b1 >= sh_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			u_s1  <= chroma_u;
			y0_s1 <= luma_first;
			v_s1  <= chroma_v;
			y1_s1 <= luma_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_pair_q <= '0;
			src_row_q  <= '0;
			dst_pair_q <= '0;
			dst_row_q  <= '0;
			col_num_q  <= '0;
			row_num_q  <= '0;
			col_base_q <= '0;
			row_base_q <= '0;
		end else if (sizes.restart || (go && src_frame_end)) begin
			src_pair_q <= '0;
			src_row_q  <= '0;
			dst_pair_q <= '0;
			dst_row_q  <= '0;
			col_num_q  <= '0;
			row_num_q  <= '0;
			col_base_q <= '0;
			row_base_q <= '0;
		end else if (go) begin
			if (src_row_end) begin
				src_pair_q <= '0;
				col_base_q <= '0;
				src_row_q  <= src_row_q + 1'b1;
				row_base_q <= row_base_q + dh_x;
			end else begin
				src_pair_q <= src_pair_q + 1'b1;
				col_base_q <= col_base_q + dw_x2;
			end
			if (hit) begin
				if (last_pair) begin
					dst_pair_q <= '0;
					col_num_q  <= '0;
					dst_row_q  <= dst_row_q + 1'b1;
					row_num_q  <= row_num_q + sh_x;
				end else begin
					dst_pair_q <= dst_pair_q + 1'b1;
					col_num_q  <= col_num_q + sw_x2;
				end
			end
		end
	end

	assign res_valid     = hit;
	assign res.u         = u_s1;
	assign res.y0        = y0_s1;
	assign res.v         = v_s1;
	assign res.y1        = y1_s1;
	assign res.col       = COORD_W'({dst_pair_q, 1'b0});
	assign res.row       = COORD_W'(dst_row_q);
	assign res.frame_end = last_pair && last_row;

endmodule

`default_nettype wire

@@ rtl/core/yuv422_nearest_downscaler.sv @@
// ----------------------------------------------------------------------------
// YUV422 nearest-neighbour downscaler
// Keeps the source macro-pixels that land on the destination grid and
// sends them out with their destination coordinates and a frame-end mark.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   chroma_u luma_first chroma_v luma_second
//   out      source     out_valid / out_stall out_u out_y0 out_v out_y1 dest_column
//                                             dest_row frame_end
//   cfg      sink       cfg_valid / cfg_ready cfg_index cfg_data
//
// One item per cycle while out is not stalled; a kept item passes through the
// input register, then the result register, on its way to out.
// Selection uses running numerators, one add and compare per counter.
// Reset or any configuration write restarts the frame counters.
// A stalled result holds the input register only when that item is kept.
// ----------------------------------------------------------------------------
`default_nettype none

`include "yuv422_nearest_downscaler_defines.svh"

module yuv422_nearest_downscaler #(
	parameter int MAX_WIDTH  = yuvds_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = yuvds_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [yuvds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [yuvds_pkg::SIZE_W-1:0]    cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [yuvds_pkg::PIX_W-1:0]     chroma_u,
	input  wire logic [yuvds_pkg::PIX_W-1:0]     luma_first,
	input  wire logic [yuvds_pkg::PIX_W-1:0]     chroma_v,
	input  wire logic [yuvds_pkg::PIX_W-1:0]     luma_second,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [yuvds_pkg::PIX_W-1:0]          out_u,
	output logic [yuvds_pkg::PIX_W-1:0]          out_y0,
	output logic [yuvds_pkg::PIX_W-1:0]          out_v,
	output logic [yuvds_pkg::PIX_W-1:0]          out_y1,
	output logic [yuvds_pkg::COORD_W-1:0]        dest_column,
	output logic [yuvds_pkg::COORD_W-1:0]        dest_row,
	output logic                                 frame_end
);
	import yuvds_pkg::*;

	sizes_t            sizes;
	result_t           res;
	result_t           res_q;
	logic              res_valid;
	logic              res_free;
	logic              out_valid_q;
	logic [SIZE_W-1:0] row_ext;
	logic [SIZE_W-1:0] col_ext;

	assign cfg_ready = 1'b1;

	yuvds_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sizes     (sizes)
	);

	yuvds_select #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_select (
		.clk         (clk),
		.arst_n      (arst_n),
		.sizes       (sizes),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.chroma_u    (chroma_u),
		.luma_first  (luma_first),
		.chroma_v    (chroma_v),
		.luma_second (luma_second),
		.res_free    (res_free),
		.res_valid   (res_valid),
		.res         (res)
	);

	assign res_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_u       = res_q.u;
	assign out_y0      = res_q.y0;
	assign out_v       = res_q.v;
	assign out_y1      = res_q.y1;
	assign dest_column = res_q.col;
	assign dest_row    = res_q.row;
	assign frame_end   = res_q.frame_end;

	assign row_ext = SIZE_W'(res_q.row);
	assign col_ext = SIZE_W'(res_q.col);

	`YDS_ASSERT(a_out_from_select, $rose(out_valid_q) |-> $past(res_valid), "result without kept item")
	`YDS_IMPLY(a_row_in_range, out_valid_q, row_ext < sizes.dh, "dest_row out of range")
	`YDS_IMPLY(a_col_in_range, out_valid_q, col_ext < sizes.dw, "dest_column out of range")
	`YDS_IMPLY(a_end_row, out_valid_q && frame_end, row_ext + 1'b1 == sizes.dh, "bad frame_end")

endmodule

`default_nettype wire
